[rtl/rgbled_pkg.sv]
package rgbled_pkg;

  // Frame layout: every LED gets green, red, blue, eight bits each, MSB first.
  localparam int BITS_PER_COLOR  = 8;
  localparam int COLORS_PER_LED  = 3;
  localparam int SLOTS_PER_LED   = BITS_PER_COLOR * COLORS_PER_LED;
  localparam int BIT_IDX_W       = $clog2(BITS_PER_COLOR);

  localparam logic [BIT_IDX_W-1:0] BIT_IDX_LAST = BIT_IDX_W'(BITS_PER_COLOR - 1);

  localparam logic [1:0] COLOR_GREEN = 2'd0;
  localparam logic [1:0] COLOR_RED   = 2'd1;
  localparam logic [1:0] COLOR_BLUE  = 2'd2;

  // Field widths
  localparam int COLOR_W   = 8;
  localparam int DUTY_W    = 10;
  localparam int LEDS_W    = 7;
  localparam int FLEN_W    = 12;

  // Duty values are cut to DUTY_BITS and then to the output field.
  localparam int DUTY_BITS = 10;
  localparam logic [DUTY_W-1:0] DUTY_MASK =
    (DUTY_BITS >= DUTY_W) ? {DUTY_W{1'b1}} : DUTY_W'((1 << DUTY_BITS) - 1);

  // Opcodes
  localparam logic OP_SET_COLOR = 1'b0;
  localparam logic OP_SLOT      = 1'b1;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_DUTY    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_DUTY     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LED_TOTAL    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_LENGTH = 3'd4;

  // Register reset values
  localparam logic [LEDS_W-1:0] LED_TOTAL_RST    = 7'd1;
  localparam logic [FLEN_W-1:0] FRAME_LENGTH_RST = 12'd24;
  localparam logic [COLOR_W-1:0] COLOR_RST       = 8'hFF;

  // Parameter defaults
  localparam int MAX_LEDS_DEF  = 64;
  localparam int MAX_SLOTS_DEF = 2048;

  typedef struct packed {
    logic              enable;
    logic [DUTY_W-1:0] zero_bit_duty;
    logic [DUTY_W-1:0] one_bit_duty;
    logic [LEDS_W-1:0] led_total;
    logic [FLEN_W-1:0] frame_length;
  } cfg_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic              slot_valid;
    logic              last_slot;
    logic              frame_started;
  } res_t;

endpackage

[rtl/rgbled_cfg_regs.sv]
module rgbled_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [rgbled_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rgbled_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output rgbled_pkg::cfg_t                   cfg
);

  rgbled_pkg::cfg_t cfg_r;
  rgbled_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        rgbled_pkg::REG_ENABLE:       cfg_nxt.enable        = cfg_wdata[0];
        rgbled_pkg::REG_ZERO_DUTY:    cfg_nxt.zero_bit_duty = cfg_wdata[rgbled_pkg::DUTY_W-1:0];
        rgbled_pkg::REG_ONE_DUTY:     cfg_nxt.one_bit_duty  = cfg_wdata[rgbled_pkg::DUTY_W-1:0];
        rgbled_pkg::REG_LED_TOTAL:    cfg_nxt.led_total     = cfg_wdata[rgbled_pkg::LEDS_W-1:0];
        rgbled_pkg::REG_FRAME_LENGTH: cfg_nxt.frame_length  = cfg_wdata[rgbled_pkg::FLEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable        <= 1'b0;
      cfg_r.zero_bit_duty <= '0;
      cfg_r.one_bit_duty  <= '0;
      cfg_r.led_total     <= rgbled_pkg::LED_TOTAL_RST;
      cfg_r.frame_length  <= rgbled_pkg::FRAME_LENGTH_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[rtl/rgbled_slot_gen.sv]
module rgbled_slot_gen #(
  parameter int MAX_LEDS  = rgbled_pkg::MAX_LEDS_DEF,
  parameter int MAX_SLOTS = rgbled_pkg::MAX_SLOTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              item_acc,
  input  logic                              opcode,
  input  logic [rgbled_pkg::COLOR_W-1:0]    red,
  input  logic [rgbled_pkg::COLOR_W-1:0]    green,
  input  logic [rgbled_pkg::COLOR_W-1:0]    blue,
  input  rgbled_pkg::cfg_t                  cfg,
  output rgbled_pkg::res_t                  res
);

  localparam int POS_W   = $clog2(MAX_SLOTS);
  localparam int LEN_W   = (POS_W + 1 > rgbled_pkg::FLEN_W) ? POS_W + 1 : rgbled_pkg::FLEN_W;
  localparam int LIDX_W  = $clog2((MAX_SLOTS - 1) / rgbled_pkg::SLOTS_PER_LED + 2);
  localparam int NLED_W  = $clog2(MAX_LEDS + 1);
  localparam int LC_A    = (LIDX_W > NLED_W) ? LIDX_W : NLED_W;
  localparam int LC_W    = (LC_A > rgbled_pkg::LEDS_W) ? LC_A : rgbled_pkg::LEDS_W;

  logic [rgbled_pkg::COLOR_W-1:0]   red_r, green_r, blue_r;
  logic [rgbled_pkg::COLOR_W-1:0]   red_nxt, green_nxt, blue_nxt;
  logic                             busy_r, busy_nxt;
  logic [POS_W-1:0]                 pos_r, pos_nxt;
  logic [rgbled_pkg::BIT_IDX_W-1:0] bit_r, bit_nxt;
  logic [1:0]                       color_r, color_nxt;
  logic [LIDX_W-1:0]                led_r, led_nxt;

  logic [LEN_W-1:0]                 eff_len;
  logic [LC_W-1:0]                  eff_leds;
  logic                             in_data;
  logic [rgbled_pkg::COLOR_W-1:0]   cur_val;
  logic                             data_bit;
  logic [rgbled_pkg::DUTY_W-1:0]    slot_duty;
  logic                             is_last;
  logic                             new_color;

  always_comb begin
    eff_len = (LEN_W'(cfg.frame_length) > LEN_W'(MAX_SLOTS)) ?
              LEN_W'(MAX_SLOTS) : LEN_W'(cfg.frame_length);
    eff_leds = (LC_W'(cfg.led_total) > LC_W'(MAX_LEDS)) ?
               LC_W'(MAX_LEDS) : LC_W'(cfg.led_total);
    in_data = LC_W'(led_r) < eff_leds;

    case (color_r)
      rgbled_pkg::COLOR_GREEN: cur_val = green_r;
      rgbled_pkg::COLOR_RED:   cur_val = red_r;
      default:                 cur_val = blue_r;
    endcase
    data_bit  = cur_val[rgbled_pkg::BIT_IDX_LAST - bit_r];
    slot_duty = in_data ?
                ((data_bit ? cfg.one_bit_duty : cfg.zero_bit_duty) & rgbled_pkg::DUTY_MASK) :
                '0;
    is_last   = (LEN_W'(pos_r) + LEN_W'(1)) >= eff_len;
    new_color = cfg.enable &&
                !(red == red_r && green == green_r && blue == blue_r);
  end

  // Result for the item at the input
  always_comb begin
    res = '0;
    if (opcode == rgbled_pkg::OP_SET_COLOR) begin
      res.frame_started = new_color;
    end else if (busy_r) begin
      res.duty       = slot_duty;
      res.slot_valid = 1'b1;
      res.last_slot  = is_last;
    end
  end

  // Frame state
  always_comb begin
    red_nxt   = red_r;
    green_nxt = green_r;
    blue_nxt  = blue_r;
    busy_nxt  = busy_r;
    pos_nxt   = pos_r;
    bit_nxt   = bit_r;
    color_nxt = color_r;
    led_nxt   = led_r;
    if (item_acc) begin
      if (opcode == rgbled_pkg::OP_SET_COLOR) begin
        if (new_color) begin
          red_nxt   = red;
          green_nxt = green;
          blue_nxt  = blue;
          busy_nxt  = cfg.frame_length != '0;
          pos_nxt   = '0;
          bit_nxt   = '0;
          color_nxt = rgbled_pkg::COLOR_GREEN;
          led_nxt   = '0;
        end
      end else if (busy_r) begin
        if (is_last) begin
          busy_nxt  = 1'b0;
          pos_nxt   = '0;
          bit_nxt   = '0;
          color_nxt = rgbled_pkg::COLOR_GREEN;
          led_nxt   = '0;
        end else begin
          pos_nxt = pos_r + POS_W'(1);
          if (bit_r == rgbled_pkg::BIT_IDX_LAST) begin
            bit_nxt = '0;
            if (color_r == rgbled_pkg::COLOR_BLUE) begin
              color_nxt = rgbled_pkg::COLOR_GREEN;
              led_nxt   = led_r + LIDX_W'(1);
            end else begin
              color_nxt = color_r + 2'd1;
            end
          end else begin
            bit_nxt = bit_r + rgbled_pkg::BIT_IDX_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_r   <= rgbled_pkg::COLOR_RST;
      green_r <= rgbled_pkg::COLOR_RST;
      blue_r  <= rgbled_pkg::COLOR_RST;
      busy_r  <= 1'b0;
      pos_r   <= '0;
      bit_r   <= '0;
      color_r <= rgbled_pkg::COLOR_GREEN;
      led_r   <= '0;
    end else begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
      busy_r  <= busy_nxt;
      pos_r   <= pos_nxt;
      bit_r   <= bit_nxt;
      color_r <= color_nxt;
      led_r   <= led_nxt;
    end
  end

endmodule

[rtl/rgbled_out_reg.sv]
module rgbled_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  rgbled_pkg::res_t res_in,
  output logic             out_valid,
  input  logic             out_stall,
  output rgbled_pkg::res_t res_out
);

  logic             valid_r;
  rgbled_pkg::res_t res_r;

  // Stall upstream only while a held result is blocked.
  assign in_stall = valid_r && out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      res_r <= res_in;
    end
  end

  assign out_valid = valid_r;
  assign res_out   = res_r;

endmodule

[rtl/rgb_led_bit_slot_encoder_top.sv]
// Serial RGB LED bit-slot encoder.
// Input channel (in_valid / in_stall): opcode 0 sets a color (in_red, in_green,
// in_blue); when enabled and different from the stored color, the color is kept
// and a new frame starts at slot zero, dropping any frame in progress.
// Opcode 1 requests the next slot and returns its PWM compare value: one_bit_duty
// or zero_bit_duty per data bit, green/red/blue MSB first for every LED, then
// zero-duty latch slots up to frame_length; no slot while no frame runs.
// Result channel (out_valid / out_stall): exactly one result per input transfer.
// The result of a transfer is registered and shown the cycle after it.
// One item per cycle unless in_stall; the frame state updates in the same cycle
// the item is taken, so a slot request may directly follow a color change.
// When the receiver stalls, the result register holds and in_stall rises only
// while a held result is blocked; the input side keeps moving otherwise.
// Configuration (cfg_wr_en / cfg_index / cfg_wdata) writes one register per
// cycle and should be written while the block is idle.
// Reset (rst_n, synchronous): no result pending, stored color white (all 255),
// no frame running, enable off, duties 0, led_total 1, frame_length 24.
module rgb_led_bit_slot_encoder_top #(
  parameter int MAX_LEDS  = rgbled_pkg::MAX_LEDS_DEF,
  parameter int MAX_SLOTS = rgbled_pkg::MAX_SLOTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_opcode,
  input  logic [rgbled_pkg::COLOR_W-1:0]    in_red,
  input  logic [rgbled_pkg::COLOR_W-1:0]    in_green,
  input  logic [rgbled_pkg::COLOR_W-1:0]    in_blue,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [rgbled_pkg::DUTY_W-1:0]     out_duty,
  output logic                              out_slot_valid,
  output logic                              out_last_slot,
  output logic                              out_frame_started,
  // configuration
  input  logic                              cfg_wr_en,
  input  logic [rgbled_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rgbled_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  rgbled_pkg::cfg_t cfg;
  rgbled_pkg::res_t res;
  rgbled_pkg::res_t res_q;
  logic             item_acc;

  // An input transfer advances the frame state in the same cycle.
  assign item_acc = in_valid && !in_stall;

  rgbled_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rgbled_slot_gen #(
    .MAX_LEDS  (MAX_LEDS),
    .MAX_SLOTS (MAX_SLOTS)
  ) u_slot (
    .clk      (clk),
    .rst_n    (rst_n),
    .item_acc (item_acc),
    .opcode   (in_opcode),
    .red      (in_red),
    .green    (in_green),
    .blue     (in_blue),
    .cfg      (cfg),
    .res      (res)
  );

  // Result register parts the two channels.
  rgbled_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .res_in    (res),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res_out   (res_q)
  );

  assign out_duty          = res_q.duty;
  assign out_slot_valid    = res_q.slot_valid;
  assign out_last_slot     = res_q.last_slot;
  assign out_frame_started = res_q.frame_started;

  // Every input transfer leaves a result waiting in the next cycle.
  a_acc_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    item_acc |=> out_valid)
    else $error("input transfer produced no result");

  // A result is either a slot or a frame start, never both.
  a_kind_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_slot_valid && out_frame_started))
    else $error("slot and frame start in one result");

  // The last-slot flag only comes with an emitted slot.
  a_last_is_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_slot) |-> out_slot_valid)
    else $error("last_slot without slot_valid");

  // Non-slot results carry zero duty.
  a_idle_duty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_slot_valid) |-> (out_duty == '0))
    else $error("nonzero duty outside a slot");

endmodule
